/* src/gwm_pkg.sv */
// gwm_pkg: shared constants and types for the glob wildcard matcher.
// Depends on nothing; used by the position cell and the top level.
package gwm_pkg;

    // Default number of pattern positions
    localparam int PATTERN_MAX_DEF = 16;
    // Pattern bytes held by the two 64-bit pattern registers
    localparam int PAT_REG_BYTES   = 16;
    localparam int BYTES_PER_WORD  = 8;

    // Configuration port geometry
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_LEN_W   = 5;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_PAT_LOW  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PAT_HIGH = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PAT_LEN  = 2'd2;

    // Wildcard characters
    localparam logic [7:0] CH_ANY  = 8'h3F;   // '?'
    localparam logic [7:0] CH_STAR = 8'h2A;   // '*'

    // Per-beat control broadcast to every cell
    typedef struct packed {
        logic       advance;    // an item beat is being consumed
        logic       restart;    // current live set is the start set
        logic [7:0] name_byte;
    } cell_ctrl_t;

    // Signals handed from one cell to the next
    typedef struct packed {
        logic start;            // position belongs to the start set
        logic step;             // previous position consumed the byte
        logic prop;             // previous position is a live star (empty run)
    } cell_link_t;

endpackage

/* src/gwm_if.sv */
// gwm_name_if / gwm_verdict_if: valid/ready channels of the glob matcher.
// Depends on nothing.
interface gwm_name_if;
    logic       valid;
    logic       ready;
    logic [7:0] name_byte;
    logic       last_byte;
    logic       empty_name;

    modport source (output valid, output name_byte, output last_byte, output empty_name,
                    input ready);
    modport sink   (input valid, input name_byte, input last_byte, input empty_name,
                    output ready);
endinterface

interface gwm_verdict_if;
    logic valid;
    logic ready;
    logic matched;

    modport source (output valid, output matched, input ready);
    modport sink   (input valid, input matched, output ready);
endinterface

/* src/gwm_cell.sv */
// gwm_cell: one pattern position of the matcher, holding its live bit.
// Depends on gwm_pkg (cell_ctrl_t, cell_link_t, wildcard constants).
module gwm_cell
    import gwm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  logic [7:0] pat_byte,
    input  logic       active,
    input  cell_link_t link_in,
    output cell_link_t link_out,
    output logic       closed,
    output logic       start
);

    logic live_reg;
    logic live_next;
    logic live;
    logic is_star;
    logic fits;

    // Decode this position's pattern byte
    assign is_star = active && (pat_byte == CH_STAR);
    assign fits    = active && !is_star && ((pat_byte == CH_ANY) || (pat_byte == ctrl.name_byte));

    // Live bit seen by this beat: start set after a name ends or a config write
    assign live = ctrl.restart ? link_in.start : live_reg;

    // New live bit: star stays, neighbour stepped in, or empty run through a star
    assign closed = (live && is_star) || link_in.step || link_in.prop;
    assign start  = link_in.start;

    assign link_out.step  = live && fits;
    assign link_out.prop  = closed && is_star;
    assign link_out.start = link_in.start && is_star;

    assign live_next = ctrl.advance ? closed : live_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg <= 1'b0;
        end
        else
        begin
            live_reg <= live_next;
        end
    end

endmodule

/* src/glob_wildcard_matcher_top.sv */
// glob_wildcard_matcher_top: streaming glob matcher built as a row of position cells.
// Depends on gwm_pkg, gwm_if (gwm_name_if, gwm_verdict_if) and gwm_cell.
//
//   channel   dir   handshake        payload
//   names     in    valid/ready      name_byte[7:0], last_byte, empty_name
//   verdicts  out   valid/ready      matched
//   cfg       in    cfg_we only      cfg_index[1:0], cfg_data[63:0]
//
// One name beat is taken every cycle unless a verdict is stalled; the live set moves through the cell row
// in the same cycle, with empty runs rippling along the star cells.
// A verdict is registered in the cycle after the beat that ends a name.
// The verdict register lets a new beat in while the old verdict is taken;
// a stalled verdict holds the names channel. Reset gives an empty pattern.
module glob_wildcard_matcher_top
    import gwm_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    gwm_name_if.sink               names,
    gwm_verdict_if.source          verdicts,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int EFF   = (PATTERN_MAX < PAT_REG_BYTES) ? PATTERN_MAX : PAT_REG_BYTES;
    localparam int LEN_W = $clog2(EFF + 1);

    logic [EFF-1:0][7:0] pat_reg;
    logic [LEN_W-1:0]    len_reg;
    logic                restart_reg;
    logic                restart_next;
    logic                out_valid_reg;
    logic                out_matched_reg;

    logic                accept;
    logic                name_end;
    logic                matched;
    logic [CFG_LEN_W-1:0] len_wr;
    logic [LEN_W-1:0]    len_sat;
    cell_ctrl_t          ctrl;
    cell_link_t          links [0:EFF];
    logic [EFF:0]        closed_vec;
    logic [EFF:0]        start_vec;

    // Handshake
    assign accept   = names.valid && names.ready;
    assign name_end = names.last_byte || names.empty_name;
    assign names.ready      = !out_valid_reg || verdicts.ready;
    assign verdicts.valid   = out_valid_reg;
    assign verdicts.matched = out_matched_reg;

    // Control broadcast to the cell row
    assign ctrl.advance   = accept && !names.empty_name;
    assign ctrl.restart   = restart_reg;
    assign ctrl.name_byte = names.name_byte;

    // Row of position cells
    assign links[0].start = 1'b1;
    assign links[0].step  = 1'b0;
    assign links[0].prop  = 1'b0;

    for (genvar i = 0; i < EFF; i++)
    begin : g_cell
        gwm_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .pat_byte (pat_reg[i]),
            .active   (LEN_W'(i) < len_reg),
            .link_in  (links[i]),
            .link_out (links[i+1]),
            .closed   (closed_vec[i]),
            .start    (start_vec[i])
        );
    end

    // Final position: nothing left to consume
    assign closed_vec[EFF] = links[EFF].step || links[EFF].prop;
    assign start_vec[EFF]  = links[EFF].start;

    // Verdict: final position live after this beat, or in the start set
    assign matched = names.empty_name ? start_vec[len_reg] : closed_vec[len_reg];

    // Length saturates at the number of cells
    assign len_wr  = cfg_data[CFG_LEN_W-1:0];
    assign len_sat = (len_wr > CFG_LEN_W'(EFF)) ? LEN_W'(EFF) : len_wr[LEN_W-1:0];

    always_comb
    begin
        restart_next = restart_reg;
        if (cfg_we && (cfg_index == CFG_PAT_LOW || cfg_index == CFG_PAT_HIGH ||
                       cfg_index == CFG_PAT_LEN))
        begin
            restart_next = 1'b1;
        end
        else if (accept)
        begin
            restart_next = name_end;
        end
    end

    // Pattern registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_reg <= '0;
            len_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PAT_LOW:
                begin
                    for (int j = 0; j < EFF; j++)
                    begin
                        if (j < BYTES_PER_WORD)
                        begin
                            pat_reg[j] <= cfg_data[8*(j % BYTES_PER_WORD) +: 8];
                        end
                    end
                end
                CFG_PAT_HIGH:
                begin
                    for (int j = 0; j < EFF; j++)
                    begin
                        if (j >= BYTES_PER_WORD)
                        begin
                            pat_reg[j] <= cfg_data[8*(j % BYTES_PER_WORD) +: 8];
                        end
                    end
                end
                CFG_PAT_LEN:
                begin
                    len_reg <= len_sat;
                end
                default:
                begin
                    len_reg <= len_reg;
                end
            endcase
        end
    end

    // Restart flag and verdict register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            restart_reg     <= 1'b1;
            out_valid_reg   <= 1'b0;
            out_matched_reg <= 1'b0;
        end
        else
        begin
            restart_reg <= restart_next;
            if (accept && name_end)
            begin
                out_valid_reg   <= 1'b1;
                out_matched_reg <= matched;
            end
            else if (verdicts.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Checks
    a_cfg_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_we && cfg_index == CFG_PAT_LEN) |=> restart_reg)
        else $error("config write did not restart the live set");

    a_end_gives_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && name_end) |=> (out_valid_reg && restart_reg))
        else $error("end of name gave no verdict");

    a_mid_no_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !name_end && !cfg_we) |=> (!out_valid_reg && !restart_reg))
        else $error("verdict raised in the middle of a name");

    a_empty_pattern: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && names.empty_name && len_reg == '0) |=> out_matched_reg)
        else $error("empty name did not match empty pattern");

endmodule
